### rtl/smd_pkg.sv
`default_nettype none

package smd_pkg;

	// Marker length in bits and the fixed field widths.
	localparam int SYNC_BITS   = 60;
	localparam int SYNC_WORD_W = 60;
	localparam int FRAME_LEN_W = 21;
	localparam int BYTE_W      = 8;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = SYNC_WORD_W;

	// One comparator lane per bit position of an input byte.
	localparam int LANES      = BYTE_W;
	localparam int LANE_IDX_W = $clog2(LANES);

	// Header split into whole bytes and a leftover of fewer than eight bits.
	localparam int HDR_BYTES = SYNC_BITS / 8;
	localparam int HDR_REM   = SYNC_BITS % 8;
	localparam int HCNT_W    = $clog2(HDR_BYTES + 1);

	// Shortest frame: the header plus at least one stream byte, byte aligned.
	localparam int MIN_LEN = ((SYNC_BITS + 15) / 8) * 8;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_WORD = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_LEN = CFG_IDX_W'(1);

	// Register reset values.
	localparam logic [SYNC_WORD_W-1:0] SYNC_WORD_RST = 60'd725483984625613973;
	localparam logic [FRAME_LEN_W-1:0] FRAME_LEN_RST = 21'd208400;

	// Selects the header bits that do not fill a whole byte.
	localparam logic [7:0] REM_MASK = 8'((1 << HDR_REM) - 1);

	typedef logic [SYNC_BITS-1:0] pattern_t;

	// Work handed from the frame tracker to the output sequencer for one item:
	// a byte closing the running frame, a header burst, and a byte after the header.
	typedef struct packed {
		logic              a_v;
		logic [BYTE_W-1:0] a_byte;
		logic              a_end;
		logic              h_v;
		logic              b_v;
		logic [BYTE_W-1:0] b_byte;
		logic              b_end;
	} smd_job_t;

endpackage

`default_nettype wire

### rtl/smd_match.sv
`default_nettype none

module smd_match (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [smd_pkg::BYTE_W-1:0]    in_byte,
	input  smd_pkg::pattern_t             pattern,
	input  logic                          take,
	output logic                          valid_s1,
	output logic [smd_pkg::BYTE_W-1:0]    byte_s1,
	output logic [smd_pkg::LANES-1:0]     match_s1
);
	import smd_pkg::*;

	logic [SYNC_BITS-1:0]        window_q;
	logic [SYNC_BITS+BYTE_W-1:0] ext;
	logic [LANES-1:0]            lane_match;
	logic                        accept;

	// The window extended by the new byte; lane j sees the window after bit j in time.
	assign ext      = {window_q, in_byte};
	assign accept   = in_valid && in_ready;
	assign in_ready = !valid_s1 || take;

	// Parallel comparator lanes, one per bit position of the byte.
	for (genvar j = 0; j < LANES; j++) begin : g_lane
		assign lane_match[j] = (ext[SYNC_BITS-1+(LANES-1-j) -: SYNC_BITS] == pattern);
	end

	// Window and stage-one valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				window_q <= ext[SYNC_BITS-1:0];
			end
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
		end
	end

	// Stage-one payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1  <= in_byte;
			match_s1 <= lane_match;
		end
	end

endmodule

`default_nettype wire

### rtl/smd_merge.sv
`default_nettype none

module smd_merge (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             valid_s1,
	input  logic [smd_pkg::BYTE_W-1:0]       byte_s1,
	input  logic [smd_pkg::LANES-1:0]        match_s1,
	input  smd_pkg::pattern_t                pattern,
	input  logic [smd_pkg::FRAME_LEN_W-1:0]  frame_len,
	input  logic                             job_free,
	output logic                             take,
	output logic                             job_valid,
	output smd_pkg::smd_job_t                job
);
	import smd_pkg::*;

	// Frame tracking state.
	logic                   cap_q;
	logic [FRAME_LEN_W-1:0] cnt_q;
	logic [6:0]             acc_q;
	logic [2:0]             nacc_q;

	logic                   cap_d;
	logic [FRAME_LEN_W-1:0] cnt_d;
	logic [6:0]             acc_d;
	logic [2:0]             nacc_d;

	logic [FRAME_LEN_W-1:0] len_floor;
	logic [FRAME_LEN_W-1:0] eff;
	logic [FRAME_LEN_W-1:0] rem;
	logic                   armed;
	logic                   over;
	logic                   ends1;
	logic                   ends2;
	logic [3:0]             t;
	logic [14:0]            cat1;
	logic [3:0]             tot1;
	logic [2:0]             sh1;
	logic [7:0]             byte1;
	logic [6:0]             acc1;
	logic [6:0]             pat_rem;
	logic [3:0]             k;
	logic [14:0]            cat2;
	logic [3:0]             tot2;
	logic                   b2_v;
	logic [2:0]             sh2;
	logic [7:0]             byte2;
	logic [6:0]             acc2;
	logic [3:0]             hunt_from;
	logic [LANES-1:0]       hv;
	logic                   found;
	logic [LANE_IDX_W-1:0]  m;

	function automatic logic [6:0] low_mask(input logic [2:0] n);
		low_mask = 7'((8'd1 << n) - 8'd1);
	endfunction

	assign take = valid_s1 && job_free;

	// Frame length rounded down to bytes and raised to the minimum.
	always_comb begin
		len_floor = {frame_len[FRAME_LEN_W-1:3], 3'b000};
		eff       = (len_floor < FRAME_LEN_W'(MIN_LEN)) ? FRAME_LEN_W'(MIN_LEN) : len_floor;
	end

	// Continuing capture: append up to eight stream bits to the partial byte.
	always_comb begin
		armed = cap_q && (cnt_q == '0);
		over  = cnt_q >= eff;
		rem   = eff - cnt_q;
		ends1 = over || (rem <= FRAME_LEN_W'(8));
		if (over) begin
			t = 4'd1;
		end else if (rem <= FRAME_LEN_W'(8)) begin
			t = rem[3:0];
		end else begin
			t = 4'd8;
		end
		cat1  = {acc_q, byte_s1} >> (4'd8 - t);
		tot1  = {1'b0, nacc_q} + t;
		sh1   = (tot1 >= 4'd8) ? 3'(tot1 - 4'd8) : tot1[2:0];
		byte1 = 8'(cat1 >> sh1);
		acc1  = cat1[6:0] & low_mask(sh1);
	end

	// Lane merge: the first lane that matched while hunting.
	always_comb begin
		if (armed) begin
			hunt_from = 4'd8;
		end else if (cap_q) begin
			hunt_from = ends1 ? t : 4'd8;
		end else begin
			hunt_from = 4'd0;
		end
		for (int j = 0; j < LANES; j++) begin
			hv[j] = match_s1[j] && (4'(j) >= hunt_from);
		end
		found = 1'b0;
		m     = '0;
		for (int j = LANES - 1; j >= 0; j--) begin
			if (hv[j]) begin
				found = 1'b1;
				m     = LANE_IDX_W'(j);
			end
		end
	end

	// After a header: the leftover header bits followed by the last k stream bits of this item.
	always_comb begin
		pat_rem = 7'(pattern[7:0] & REM_MASK);
		k       = armed ? 4'd8 : (4'd7 - {1'b0, m});
		cat2    = {pat_rem, 8'(byte_s1 << (4'd8 - k))} >> (4'd8 - k);
		tot2    = 4'(HDR_REM) + k;
		b2_v    = tot2 >= 4'd8;
		sh2     = b2_v ? 3'(tot2 - 4'd8) : tot2[2:0];
		byte2   = 8'(cat2 >> sh2);
		acc2    = cat2[6:0] & low_mask(sh2);
		ends2   = FRAME_LEN_W'(SYNC_BITS + 8) >= eff;
	end

	// Next state and the work for the output sequencer.
	always_comb begin
		cap_d  = cap_q;
		cnt_d  = cnt_q;
		acc_d  = acc_q;
		nacc_d = nacc_q;
		job    = '0;
		if (armed) begin
			job.h_v    = 1'b1;
			job.b_v    = b2_v;
			job.b_byte = byte2;
			job.b_end  = ends2;
			if (ends2) begin
				cap_d  = 1'b0;
				cnt_d  = '0;
				acc_d  = '0;
				nacc_d = '0;
			end else begin
				cnt_d  = FRAME_LEN_W'(SYNC_BITS + 8);
				acc_d  = acc2;
				nacc_d = sh2;
			end
		end else if (cap_q && !ends1) begin
			job.a_v    = 1'b1;
			job.a_byte = byte1;
			cnt_d      = cnt_q + FRAME_LEN_W'(t);
			acc_d      = acc1;
			nacc_d     = sh1;
		end else begin
			// Close the running frame, if any, then hunt over the rest of the item.
			if (cap_q) begin
				job.a_v    = tot1 >= 4'd8;
				job.a_byte = byte1;
				job.a_end  = 1'b1;
			end
			cap_d  = found;
			cnt_d  = '0;
			acc_d  = '0;
			nacc_d = '0;
			if (found && (m != LANE_IDX_W'(LANES - 1))) begin
				job.h_v    = 1'b1;
				job.b_v    = b2_v;
				job.b_byte = byte2;
				cnt_d      = FRAME_LEN_W'(SYNC_BITS) + FRAME_LEN_W'(k);
				acc_d      = acc2;
				nacc_d     = sh2;
			end
		end
		job_valid = take && (job.a_v || job.h_v || job.b_v);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= 1'b0;
			cnt_q  <= '0;
			acc_q  <= '0;
			nacc_q <= '0;
		end else if (take) begin
			cap_q  <= cap_d;
			cnt_q  <= cnt_d;
			acc_q  <= acc_d;
			nacc_q <= nacc_d;
		end
	end

	// While hunting no frame bits are counted or held.
	a_hunt_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!cap_q |-> (cnt_q == '0) && (nacc_q == '0) && (acc_q == '0))
		else $error("frame state not clear while hunting");

	// A started frame always holds the full header.
	a_hdr_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(cap_q && (cnt_q != '0)) |-> (cnt_q >= FRAME_LEN_W'(SYNC_BITS)))
		else $error("frame bit count below header length");

endmodule

`default_nettype wire

### rtl/smd_emit.sv
`default_nettype none

module smd_emit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          job_in_valid,
	input  smd_pkg::smd_job_t             job_in,
	input  smd_pkg::pattern_t             pattern,
	output logic                          job_free,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [smd_pkg::BYTE_W-1:0]    m_tdata,
	output logic                          m_tlast,
	output logic [1:0]                    m_tuser
);
	import smd_pkg::*;

	smd_job_t          job_s2;
	logic              job_valid_s2;
	logic [HCNT_W-1:0] hcnt_q;
	pattern_t          hdr_q;

	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_start_q;
	logic              out_end_q;
	logic              out_lio_q;

	logic              load;
	logic              send_a;
	logic              send_h;
	logic              send_b;
	logic              hdr_last;
	logic              last_piece;
	logic [BYTE_W-1:0] sel_byte;
	logic              sel_start;
	logic              sel_end;

	// Pick the next piece of the current item: closing byte, header bytes, trailing byte.
	always_comb begin
		load      = job_valid_s2 && (!out_valid_q || m_tready);
		send_a    = job_s2.a_v;
		send_h    = !job_s2.a_v && job_s2.h_v;
		send_b    = !job_s2.a_v && !job_s2.h_v && job_s2.b_v;
		hdr_last  = hcnt_q == HCNT_W'(HDR_BYTES - 1);
		last_piece = send_b
			|| (send_h && hdr_last && !job_s2.b_v)
			|| (send_a && !job_s2.h_v && !job_s2.b_v);
		job_free  = !job_valid_s2 || (load && last_piece);
		sel_byte  = job_s2.b_byte;
		sel_start = 1'b0;
		sel_end   = job_s2.b_end;
		if (send_a) begin
			sel_byte = job_s2.a_byte;
			sel_end  = job_s2.a_end;
		end else if (send_h) begin
			sel_byte  = hdr_q[SYNC_BITS-1 -: BYTE_W];
			sel_start = hcnt_q == '0;
			sel_end   = 1'b0;
		end
	end

	// Item register and header sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_s2 <= 1'b0;
			job_s2       <= '0;
			hcnt_q       <= '0;
		end else if (job_free) begin
			job_valid_s2 <= job_in_valid;
			if (job_in_valid) begin
				job_s2 <= job_in;
				hcnt_q <= '0;
			end
		end else if (load) begin
			if (send_a) begin
				job_s2.a_v <= 1'b0;
			end else if (send_h) begin
				hcnt_q <= hcnt_q + 1'b1;
				if (hdr_last) begin
					job_s2.h_v <= 1'b0;
				end
			end
		end
	end

	// Header bytes leave from the top of a shift register loaded with the marker.
	always_ff @(posedge clk) begin
		if (job_free && job_in_valid) begin
			hdr_q <= pattern;
		end else if (load && send_h) begin
			hdr_q <= hdr_q << BYTE_W;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q  <= sel_byte;
			out_start_q <= sel_start;
			out_end_q   <= sel_end;
			out_lio_q   <= last_piece;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tlast  = out_end_q;
	assign m_tuser  = {out_lio_q, out_start_q};

	// A held item always has something left to send.
	a_job_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid_s2 |-> (job_s2.a_v || job_s2.h_v || job_s2.b_v))
		else $error("empty item held in output sequencer");

	// The header counter stays inside the header.
	a_hcnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(job_valid_s2 && job_s2.h_v) |-> (hcnt_q < HCNT_W'(HDR_BYTES)))
		else $error("header byte counter out of range");

	// A frame start byte is always followed by more header bytes.
	a_start_follow: assert property (@(posedge clk) disable iff (!arst_n)
		(load && send_h && (hcnt_q == '0)) |-> !last_piece || (HDR_BYTES == 1))
		else $error("frame start byte marked as last of item");

endmodule

`default_nettype wire

### rtl/sync_marker_deframer_unit.sv
`default_nettype none

// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tdata: data_byte
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata: frame_byte, tlast: frame_end,
//                                                     tuser: frame_start, last_of_input
// cfg       in         cfg_valid / cfg_ready          cfg_index, cfg_data
//
// One input byte per cycle is taken unless a held item or an output stall holds it back; its
// first result byte reaches m_axis through the match stage, item register and output register.
// An item yields up to nine bytes (a closing byte, SYNC_BITS/8 header bytes and one more),
// one per output cycle while m_axis_tready allows; input waits until the last of them is loaded.
// Reset clears the bit window and the frame state and loads the register defaults.
// Output stalls propagate back to s_axis_tready through the single output register.

module sync_marker_deframer_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [7:0]                        s_axis_tdata,  // [7:0] data_byte
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [7:0]                        m_axis_tdata,  // [7:0] frame_byte
	output logic                              m_axis_tlast,
	output logic [1:0]                        m_axis_tuser,  // [0] frame_start, [1] last_of_input
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [smd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [smd_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import smd_pkg::*;

	logic [SYNC_WORD_W-1:0] sync_word_q;
	logic [FRAME_LEN_W-1:0] frame_len_q;
	pattern_t               pattern;

	logic                   valid_s1;
	logic [BYTE_W-1:0]      byte_s1;
	logic [LANES-1:0]       match_s1;
	logic                   take;
	logic                   job_free;
	logic                   job_valid;
	smd_job_t               job;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_word_q <= SYNC_WORD_RST;
			frame_len_q <= FRAME_LEN_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SYNC_WORD: sync_word_q <= SYNC_WORD_W'(cfg_data);
				REG_FRAME_LEN: frame_len_q <= FRAME_LEN_W'(cfg_data);
				default: begin
				end
			endcase
		end
	end

	assign pattern = SYNC_BITS'(sync_word_q);

	smd_match u_match (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (s_axis_tdata),
		.pattern  (pattern),
		.take     (take),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1),
		.match_s1 (match_s1)
	);

	smd_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.byte_s1   (byte_s1),
		.match_s1  (match_s1),
		.pattern   (pattern),
		.frame_len (frame_len_q),
		.job_free  (job_free),
		.take      (take),
		.job_valid (job_valid),
		.job       (job)
	);

	smd_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_in_valid (job_valid),
		.job_in       (job),
		.pattern      (pattern),
		.job_free     (job_free),
		.m_tvalid     (m_axis_tvalid),
		.m_tready     (m_axis_tready),
		.m_tdata      (m_axis_tdata),
		.m_tlast      (m_axis_tlast),
		.m_tuser      (m_axis_tuser)
	);

endmodule

`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import smd_pkg::*;

	localparam int DRAIN_CYCLES = 16;
	localparam int LONG_PAYLOAD = 1024;

	// One expected output byte of the deframer.
	typedef struct packed {
		logic [7:0] data;
		logic       is_first;
		logic       is_end;
		logic       closes_item;
	} frame_byte_t;

	// Tracks the frame synchronizer state and holds the frame bytes still to come out.
	class frame_tracker;
		logic [SYNC_WORD_W-1:0] marker;
		logic [FRAME_LEN_W-1:0] length_reg;
		pattern_t               window;
		bit                     capturing;
		int                     frame_bits;
		logic [7:0]             acc;
		int                     acc_bits;
		frame_byte_t            pending[$];
		int                     error_count;

		function new();
			marker      = 60'd725483984625613973;
			length_reg  = 21'd208400;
			window      = '0;
			capturing   = 1'b0;
			frame_bits  = 0;
			acc         = '0;
			acc_bits    = 0;
			error_count = 0;
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
			if (idx == REG_SYNC_WORD) begin
				marker = value[SYNC_WORD_W-1:0];
			end else if (idx == REG_FRAME_LEN) begin
				length_reg = value[FRAME_LEN_W-1:0];
			end
		endfunction

		// The length is cut down to whole bytes and raised to header plus one stream byte.
		function int frame_length();
			int len;
			int shortest;
			len = int'(length_reg) & ~7;
			shortest = ((SYNC_BITS + 8 + 7) / 8) * 8;
			return (len < shortest) ? shortest : len;
		endfunction

		// Adds one bit to the frame and books a byte once eight bits are in.
		function void emit_frame_bit(logic b, int len);
			frame_byte_t produced;
			acc = {acc[6:0], b};
			acc_bits++;
			frame_bits++;
			if (acc_bits == 8) begin
				produced.data        = acc;
				produced.is_first    = (frame_bits == 8);
				produced.is_end      = (frame_bits >= len);
				produced.closes_item = 1'b0;
				pending = {pending, produced};
				acc_bits = 0;
				acc      = '0;
			end
		endfunction

		// Runs the eight bits of one accepted item through the hunt and capture logic.
		function void take_stream_byte(logic [7:0] data);
			pattern_t    pattern;
			frame_byte_t tail;
			int          len;
			int          before_count;
			int          i;
			int          k;
			logic        b;
			pattern      = marker[SYNC_BITS-1:0];
			len          = frame_length();
			before_count = pending.size();
			for (i = 7; i >= 0; i--) begin
				b      = data[i];
				window = {window[SYNC_BITS-2:0], b};
				if (capturing) begin
					// The header goes out in front of the first captured bit.
					if (frame_bits == 0) begin
						for (k = SYNC_BITS - 1; k >= 0; k--)
							emit_frame_bit(pattern[k], len);
					end
					emit_frame_bit(b, len);
					if (frame_bits >= len) begin
						capturing  = 1'b0;
						frame_bits = 0;
						acc_bits   = 0;
						acc        = '0;
					end
				end else if (window == pattern) begin
					capturing  = 1'b1;
					frame_bits = 0;
					acc_bits   = 0;
					acc        = '0;
				end
			end
			// Flag the final byte that this item produced.
			if (pending.size() > before_count) begin
				tail = pending.pop_back();
				tail.closes_item = 1'b1;
				pending = {pending, tail};
			end
		endfunction

		function void check_frame_byte(logic [7:0] data, logic is_first, logic is_end,
				logic closes_item);
			frame_byte_t want;
			if (pending.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("%0t: unexpected frame byte %02h start %0b end %0b last_of_input %0b",
						$time, data, is_first, is_end, closes_item);
				return;
			end
			want = pending.pop_front();
			if (want.data !== data || want.is_first !== is_first || want.is_end !== is_end ||
					want.closes_item !== closes_item) begin
				error_count++;
				// Fields: byte, start, end, last_of_input.
				if (error_count <= 10)
					$display("%0t: mismatch, expected %02h %0b %0b %0b, got %02h %0b %0b %0b",
						$time, want.data, want.is_first, want.is_end, want.closes_item,
						data, is_first, is_end, closes_item);
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [7:0]             s_axis_tdata;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [7:0]             m_axis_tdata;
	logic                   m_axis_tlast;
	logic [1:0]             m_axis_tuser;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	frame_tracker tracker;
	int           send_gap_pct;
	int           recv_stall_pct;
	bit           tx_bits[$];

	sync_marker_deframer_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial begin
		#20_000_000;
		$display("testbench: done, errors");
		$finish;
	end

	// Output side: check every accepted frame byte, then pick the next ready level.
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready)
				tracker.check_frame_byte(m_axis_tdata, m_axis_tuser[0], m_axis_tlast,
					m_axis_tuser[1]);
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Presents one stream byte after a random gap and waits until it is taken.
	task automatic send_byte(logic [7:0] value);
		while ($urandom_range(99) < send_gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= value;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		tracker.take_stream_byte(value);
	endtask

	function automatic void queue_bits(logic [63:0] value, int count);
		int i;
		for (i = count - 1; i >= 0; i--)
			tx_bits = {tx_bits, bit'(value[i])};
	endfunction

	function automatic void queue_random_bits(int count);
		int i;
		for (i = 0; i < count; i++)
			tx_bits = {tx_bits, bit'($urandom_range(1))};
	endfunction

	// Packs queued stream bits into bytes, first bit in the MSB, and sends them.
	task automatic send_queued_bits();
		logic [7:0] value;
		int         i;
		while (tx_bits.size() >= 8) begin
			for (i = 7; i >= 0; i--)
				value[i] = tx_bits.pop_front();
			send_byte(value);
		end
	endtask

	// Pads to a byte boundary and keeps feeding random bytes until no frame is open.
	task automatic close_frames();
		queue_random_bits((8 - tx_bits.size() % 8) % 8);
		send_queued_bits();
		while (tracker.capturing)
			send_byte(8'($urandom));
	endtask

	// Waits until every expected byte is out and the pipeline has settled.
	task automatic quiesce();
		s_axis_tvalid <= 1'b0;
		while (tracker.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic program_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		tracker.write_register(idx, value);
	endtask

	// Writes both registers; the length word carries junk above its 21 bits.
	task automatic apply_setting(logic [SYNC_WORD_W-1:0] marker, logic [FRAME_LEN_W-1:0] len);
		logic [CFG_DATA_W-1:0] len_word;
		len_word = CFG_DATA_W'({$urandom, $urandom});
		len_word[FRAME_LEN_W-1:0] = len;
		program_register(REG_SYNC_WORD, marker);
		program_register(REG_FRAME_LEN, len_word);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [SYNC_WORD_W-1:0] random_marker();
		return SYNC_WORD_W'({$urandom, $urandom});
	endfunction

	function automatic logic [FRAME_LEN_W-1:0] random_length();
		if ($urandom_range(4) == 0)
			return FRAME_LEN_W'($urandom_range(71));
		return FRAME_LEN_W'($urandom_range(160, 72));
	endfunction

	// Line noise, now and then a damaged marker, then the marker and a payload.
	function automatic void queue_frame();
		pattern_t pattern;
		int       payload_bits;
		int       keep;
		int       i;
		pattern      = tracker.marker[SYNC_BITS-1:0];
		payload_bits = tracker.frame_length() - SYNC_BITS;
		queue_random_bits($urandom_range(20));
		case ($urandom_range(9))
			0: begin
				queue_bits(64'(pattern) ^ (64'd1 << $urandom_range(SYNC_BITS - 1)), SYNC_BITS);
			end
			1: begin
				keep = $urandom_range(SYNC_BITS - 1, 8);
				queue_bits(64'(pattern) >> (SYNC_BITS - keep), keep);
			end
			default: begin
			end
		endcase
		queue_bits(64'(pattern), SYNC_BITS);
		// Very long frames get their payload from close_frames instead.
		if (payload_bits > LONG_PAYLOAD)
			payload_bits = 0;
		// Some payloads repeat the marker so that matches land inside a capture.
		if ($urandom_range(3) == 0) begin
			for (i = 0; i < payload_bits; i++)
				tx_bits = {tx_bits, bit'(pattern[SYNC_BITS - 1 - i % SYNC_BITS])};
		end else begin
			queue_random_bits(payload_bits);
		end
	endfunction

	task automatic run_setting(logic [SYNC_WORD_W-1:0] marker, logic [FRAME_LEN_W-1:0] len,
			int frames);
		int n;
		apply_setting(marker, len);
		for (n = 0; n < frames; n++) begin
			queue_frame();
			send_queued_bits();
		end
		close_frames();
		quiesce();
	endtask

	initial begin
		tracker        = new();
		send_gap_pct   = 33;
		recv_stall_pct = 65;
		arst_n         = 1'b0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		cfg_valid      = 1'b0;
		cfg_index      = REG_SYNC_WORD;
		cfg_data       = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Hunting on byte extremes with the registers at their reset values.
		send_byte(8'h00);
		send_byte(8'hFF);
		quiesce();

		// Too short a length, then a frame on the reset marker, byte aligned.
		program_register(REG_FRAME_LEN, '0);
		cfg_valid <= 1'b0;
		queue_bits(64'(tracker.marker), SYNC_BITS);
		queue_random_bits(12);
		send_queued_bits();
		close_frames();
		quiesce();

		// Zero marker on a zero stream: back-to-back frames that rematch on the next bit.
		apply_setting('0, 21'd77);
		repeat (17) send_byte(8'h00);
		close_frames();
		quiesce();

		run_setting(random_marker(), random_length(), 2);
		run_setting('1, 21'd80, 2);
		run_setting(random_marker(), FRAME_LEN_W'($urandom_range(71)), 1);

		send_gap_pct   = 65;
		recv_stall_pct = 33;
		run_setting('0, 21'd72, 2);
		run_setting(random_marker(), random_length(), 2);
		run_setting(random_marker(), random_length(), 1);

		send_gap_pct   = 0;
		recv_stall_pct = 0;
		run_setting(random_marker(), random_length(), 2);
		run_setting(random_marker(), 21'd72, 2);

		if (tracker.error_count == 0 && tracker.pending.size() == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule

### files.f
rtl/smd_pkg.sv
rtl/smd_match.sv
rtl/smd_merge.sv
rtl/smd_emit.sv
rtl/sync_marker_deframer_unit.sv
verif/testbench.sv
